[hdl/nps_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the nearest point search block.
// No dependencies; used by nps_dist, nearest_point_search_core and the testbench.
package nps_pkg;

   localparam int MAX_POINTS  = 1024;
   localparam int COORD_BITS  = 16;
   localparam int ADDR_W      = $clog2(MAX_POINTS);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int PT_W        = 3 * COORD_BITS;
   localparam int DIFF_W      = COORD_BITS + 1;
   localparam int SQ_W        = 2 * COORD_BITS + 1;
   localparam int DIST_W      = 2 * COORD_BITS + 2;

   localparam int FIELD_W     = 16;
   localparam int TAG_W       = 10;
   localparam int OP_W        = 2;
   localparam int INDEX_OUT_W = 10;
   localparam int DIST_OUT_W  = 34;
   localparam int THR_W       = 34;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 56;
   localparam int RSP_PAD_W   = RSP_TDATA_W - TAG_W - INDEX_OUT_W - DIST_OUT_W;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] index;
      logic [DIST_W-1:0] dist_sq;
   } cand_type;

endpackage

[hdl/nearest_point_search_core.sv]
`timescale 1ns / 1ps
// Clear and append beats are taken in the idle state. A query's result beat is loaded once
// the scan, the read register and the distance pipeline have drained, or without a scan on an empty
// store: the single read port of the point memory delivers one stored point per cycle,
// walked from the highest index down, and an early match ends the walk sooner. One query
// is in work at a time; a finished result waits in an output register, so a stalled
// result side blocks requests only once the next query has finished.
// Synchronous reset empties the store and zeroes the threshold; point memory is not cleared.
module nearest_point_search_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // coord_x, coord_y, coord_z, query_tag, zero fill
   input  logic [nps_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode
   input  logic [nps_pkg::OP_W-1:0]          req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tag_out, match_index, match_dist_sq, zero fill
   output logic [nps_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // found
   output logic [0:0]                        rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nps_pkg::THR_W-1:0]         csr_data
);

   nps_pkg::state_type               state_ff, state_in;
   logic [nps_pkg::CNT_W-1:0]        count_ff, count_in, count_m1;
   logic [nps_pkg::THR_W-1:0]        thr_ff;
   logic [nps_pkg::PT_W-1:0]         query_ff, query_in, req_point;
   logic [nps_pkg::TAG_W-1:0]        tag_ff, tag_in;
   logic [nps_pkg::ADDR_W-1:0]       scan_ff, scan_in;
   logic                             rd_vld_ff;
   logic [nps_pkg::ADDR_W-1:0]       rd_idx_ff;
   logic [nps_pkg::PT_W-1:0]         rd_data_ff;
   logic                             rd_en;
   logic                             mem_we;
   logic                             clear_best;
   logic [nps_pkg::DIST_W-1:0]       best_ff, best_in;
   logic [nps_pkg::ADDR_W-1:0]       best_idx_ff, best_idx_in;
   logic                             have_ff, have_in;
   logic                             hit_ff, hit_in;
   logic                             dist_busy;
   logic                             out_load;
   logic                             out_vld_ff;
   logic [nps_pkg::RSP_TDATA_W-1:0]  out_data_ff;
   logic                             out_found_ff;
   nps_pkg::cand_type                cand;
   logic [nps_pkg::PT_W-1:0]         mem [nps_pkg::MAX_POINTS];

   assign req_point = {req_tdata[2*nps_pkg::FIELD_W +: nps_pkg::COORD_BITS],
                       req_tdata[nps_pkg::FIELD_W +: nps_pkg::COORD_BITS],
                       req_tdata[0 +: nps_pkg::COORD_BITS]};
   assign count_m1  = count_ff - nps_pkg::CNT_W'(1);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= nps_pkg::ST_IDLE;
         count_ff   <= '0;
         thr_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         have_ff    <= 1'b0;
         hit_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_en;
         have_ff   <= have_in;
         hit_ff    <= hit_in;
         if (csr_valid) begin
            thr_ff <= csr_data;
         end
         if (out_load) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      query_ff    <= query_in;
      tag_ff      <= tag_in;
      scan_ff     <= scan_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      if (out_load) begin
         out_data_ff  <= {{nps_pkg::RSP_PAD_W{1'b0}},
                          nps_pkg::DIST_OUT_W'(best_ff),
                          nps_pkg::INDEX_OUT_W'(best_idx_ff),
                          tag_ff};
         out_found_ff <= have_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[nps_pkg::ADDR_W-1:0]] <= req_point;
      end
      if (rd_en) begin
         rd_data_ff <= mem[scan_ff];
      end
      rd_idx_ff <= scan_ff;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      query_in   = query_ff;
      tag_in     = tag_ff;
      scan_in    = scan_ff;
      req_tready = 1'b0;
      out_load   = 1'b0;
      mem_we     = 1'b0;
      rd_en      = 1'b0;
      clear_best = 1'b0;
      unique case (state_ff)
         nps_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_tuser)
                  nps_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  nps_pkg::OP_APPEND: begin
                     if (count_ff < nps_pkg::CNT_W'(nps_pkg::MAX_POINTS)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + nps_pkg::CNT_W'(1);
                     end
                  end
                  nps_pkg::OP_QUERY: begin
                     query_in   = req_point;
                     tag_in     = req_tdata[3*nps_pkg::FIELD_W +: nps_pkg::TAG_W];
                     scan_in    = count_m1[nps_pkg::ADDR_W-1:0];
                     clear_best = 1'b1;
                     if (count_ff == '0) begin
                        state_in = nps_pkg::ST_RESP;
                     end else begin
                        state_in = nps_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         nps_pkg::ST_SCAN: begin
            rd_en = !hit_ff;
            if (hit_ff || scan_ff == '0) begin
               state_in = nps_pkg::ST_DRAIN;
            end else begin
               scan_in = scan_ff - nps_pkg::ADDR_W'(1);
            end
         end
         nps_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !dist_busy && !cand.valid) begin
               state_in = nps_pkg::ST_RESP;
            end
         end
         nps_pkg::ST_RESP: begin
            if (!out_vld_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = nps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nps_pkg::ST_IDLE;
         end
      endcase
   end

   // Points arrive in descending index order; only a strictly smaller distance
   // replaces the best, so ties keep the higher index.
   always_comb begin
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      have_in     = have_ff;
      hit_in      = hit_ff;
      if (clear_best) begin
         best_in     = '0;
         best_idx_in = '0;
         have_in     = 1'b0;
         hit_in      = 1'b0;
      end else if (cand.valid && !hit_ff) begin
         if (!have_ff || cand.dist_sq < best_ff) begin
            best_in     = cand.dist_sq;
            best_idx_in = cand.index;
            have_in     = 1'b1;
         end
         if (cand.dist_sq < thr_ff) begin
            hit_in = 1'b1;
         end
      end
   end

   nps_dist u_dist (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (rd_vld_ff),
      .in_index    (rd_idx_ff),
      .query_point (query_ff),
      .ref_point   (rd_data_ff),
      .cand        (cand),
      .busy        (dist_busy)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_found_ff;

   a_resp_after_drain: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rd_vld_ff && !dist_busy && !cand.valid))
      else $error("result beat loaded while distance pipeline still busy");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == nps_pkg::ST_IDLE && count_ff < nps_pkg::CNT_W'(nps_pkg::MAX_POINTS)))
      else $error("point memory written outside idle or past capacity");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= nps_pkg::CNT_W'(nps_pkg::MAX_POINTS))
      else $error("point count exceeds capacity");

   a_found_needs_points: assert property (@(posedge clock) disable iff (reset)
      (out_load && have_ff) |-> (count_ff != '0))
      else $error("found flag set on an empty store");

   a_no_read_after_hit: assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> !rd_en)
      else $error("memory read issued after early stop");

endmodule

[hdl/nps_dist.sv]
`timescale 1ns / 1ps
// Two-stage squared Euclidean distance pipeline between a query and a stored point.
// Depends on nps_pkg.
module nps_dist (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [nps_pkg::ADDR_W-1:0]  in_index,
   input  logic [nps_pkg::PT_W-1:0]    query_point,
   input  logic [nps_pkg::PT_W-1:0]    ref_point,
   output nps_pkg::cand_type           cand,
   output logic                        busy
);

   logic signed [nps_pkg::DIFF_W-1:0]   diff [3];
   logic signed [2*nps_pkg::DIFF_W-1:0] prod [3];
   logic [nps_pkg::SQ_W-1:0]            sq_in [3];
   logic [nps_pkg::SQ_W-1:0]            sq_ff [3];
   logic                                sq_vld_ff;
   logic [nps_pkg::ADDR_W-1:0]          sq_idx_ff;
   logic [nps_pkg::DIST_W-1:0]          sum_in;
   logic [nps_pkg::DIST_W-1:0]          sum_ff;
   logic                                sum_vld_ff;
   logic [nps_pkg::ADDR_W-1:0]          sum_idx_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k] = $signed({query_point[k*nps_pkg::COORD_BITS + nps_pkg::COORD_BITS-1],
                            query_point[k*nps_pkg::COORD_BITS +: nps_pkg::COORD_BITS]})
                 - $signed({ref_point[k*nps_pkg::COORD_BITS + nps_pkg::COORD_BITS-1],
                            ref_point[k*nps_pkg::COORD_BITS +: nps_pkg::COORD_BITS]});
         prod[k]  = diff[k] * diff[k];
         sq_in[k] = prod[k][nps_pkg::SQ_W-1:0];
      end
   end

   assign sum_in = nps_pkg::DIST_W'(sq_ff[0]) + nps_pkg::DIST_W'(sq_ff[1])
                 + nps_pkg::DIST_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff  <= 1'b0;
         sum_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff  <= in_valid;
         sum_vld_ff <= sq_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         sq_ff[k] <= sq_in[k];
      end
      sq_idx_ff  <= in_index;
      sum_ff     <= sum_in;
      sum_idx_ff <= sq_idx_ff;
   end

   assign cand.valid   = sum_vld_ff;
   assign cand.index   = sum_idx_ff;
   assign cand.dist_sq = sum_ff;
   assign busy         = sq_vld_ff | sum_vld_ff;

endmodule

[tb/sv/tb_nearest_point_search_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for nearest_point_search_core: directed table, then random phases.
// Depends on nps_pkg and the core; expected matches come from the directed table or from a predictor kept in this file.
module tb_nearest_point_search_core;
   import nps_pkg::*;

   localparam logic [OP_W-1:0]  OP_UNUSED     = 2'd3;
   localparam logic [THR_W-1:0] THR_MAX       = '1;
   localparam int               RANDOM_ITEMS  = 450;
   localparam int               SETTLE_CYCLES = 16;
   localparam int               HOLD_CYCLES   = 400;
   localparam int               DIRECTED_ROWS = 18;
   localparam longint           LIMIT_NS      = 64'd8_000_000;

   typedef struct packed {
      logic [TAG_W-1:0]       tag;
      logic [INDEX_OUT_W-1:0] index;
      logic [DIST_OUT_W-1:0]  dist_sq;
      logic                   found;
   } match_type;

   typedef struct packed {
      logic [OP_W-1:0]              op;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic [TAG_W-1:0]             tag;
      logic                         has_exp;
      match_type                    exp;
   } request_type;

   localparam match_type NO_EXP = '0;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]        req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [THR_W-1:0]       csr_data   = '0;

   // Predictor state.
   logic signed [COORD_BITS-1:0] store_x [MAX_POINTS];
   logic signed [COORD_BITS-1:0] store_y [MAX_POINTS];
   logic signed [COORD_BITS-1:0] store_z [MAX_POINTS];
   logic [CNT_W-1:0]             stored_count    = '0;
   logic [THR_W-1:0]             match_threshold = '0;
   match_type                    nearest_results[$];

   request_type request_beats[$];
   request_type bus_item;
   bit       req_accepted   = 1'b0;
   int       gap_left       = 0;
   int       burst_left     = 0;
   int       hold_request   = 0;
   int       hold_left      = 0;
   int       ready_cycle    = 0;
   int       stall_mode     = 0;
   int       random_items   = 0;
   int       mismatch_count = 0;

   request_type directed_table [DIRECTED_ROWS] = '{
      '{OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 10'd1023, 1'b1,
        '{10'd1023, 10'd0, 34'd0, 1'b0}},
      '{OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023, 1'b0, NO_EXP},
      '{OP_APPEND, 16'h8000, 16'h8000, 16'h8000, 10'd0,    1'b0, NO_EXP},
      '{OP_QUERY,  16'h7FFF, 16'h7FFF, 16'h7FFF, 10'd0,    1'b1,
        '{10'd0, 10'd0, 34'd12884508675, 1'b1}},
      '{OP_QUERY,  16'h8000, 16'h8000, 16'h8000, 10'd5,    1'b1,
        '{10'd5, 10'd0, 34'd0, 1'b1}},
      '{OP_APPEND, 16'h7FFF, 16'h7FFF, 16'h7FFF, 10'd0,    1'b0, NO_EXP},
      '{OP_APPEND, 16'h0000, 16'h0000, 16'h0000, 10'd0,    1'b0, NO_EXP},
      '{OP_APPEND, 16'h0000, 16'h0000, 16'h0000, 10'd0,    1'b0, NO_EXP},
      '{OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 10'd9,    1'b1,
        '{10'd9, 10'd3, 34'd0, 1'b1}},
      '{OP_QUERY,  16'h0001, 16'hFFFF, 16'h0000, 10'd10,   1'b0, NO_EXP},
      '{OP_UNUSED, 16'h0000, 16'h0000, 16'h0000, 10'd0,    1'b0, NO_EXP},
      '{OP_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd0,    1'b0, NO_EXP},
      '{OP_QUERY,  16'h7FFF, 16'h7FFF, 16'h7FFE, 10'h155,  1'b0, NO_EXP},
      '{OP_QUERY,  16'h8000, 16'h7FFF, 16'h8000, 10'h2AA,  1'b0, NO_EXP},
      '{OP_CLEAR,  16'h1234, 16'h5678, 16'h9ABC, 10'h3FF,  1'b0, NO_EXP},
      '{OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 10'h200,  1'b1,
        '{10'h200, 10'd0, 34'd0, 1'b0}},
      '{OP_APPEND, 16'h0064, 16'h00C8, 16'hFED4, 10'd0,    1'b0, NO_EXP},
      '{OP_QUERY,  16'h0065, 16'h00C8, 16'hFED4, 10'h0FF,  1'b0, NO_EXP}
   };

   nearest_point_search_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("tb_nearest_point_search_core: done, errors");
      $finish;
   end

   function automatic logic [DIST_OUT_W-1:0] point_dist(request_type q, int slot);
      longint dx, dy, dz;
      dx = longint'(q.x) - longint'(store_x[slot]);
      dy = longint'(q.y) - longint'(store_y[slot]);
      dz = longint'(q.z) - longint'(store_z[slot]);
      return DIST_OUT_W'(dx * dx + dy * dy + dz * dz);
   endfunction

   function automatic match_type nearest_of(request_type q);
      match_type             best;
      logic [DIST_OUT_W-1:0] d;
      best = '0;
      best.tag = q.tag;
      for (int j = int'(stored_count) - 1; j >= 0; j--) begin
         d = point_dist(q, j);
         if (!best.found || d < best.dist_sq) begin
            best.dist_sq = d;
            best.index   = INDEX_OUT_W'(j);
            best.found   = 1'b1;
         end
         if (d < match_threshold) break;
      end
      return best;
   endfunction

   function automatic void track_item(request_type it);
      case (it.op)
         OP_CLEAR: stored_count = '0;
         OP_APPEND: begin
            if (stored_count < MAX_POINTS) begin
               store_x[stored_count] = it.x;
               store_y[stored_count] = it.y;
               store_z[stored_count] = it.z;
               stored_count++;
            end
         end
         OP_QUERY: nearest_results = {nearest_results, (it.has_exp ? it.exp : nearest_of(it))};
         default: ;
      endcase
   endfunction

   function automatic void check_result(match_type got);
      match_type want;
      if (nearest_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result beat: tag %0d index %0d dist %0d found %0d",
                     got.tag, got.index, got.dist_sq, got.found);
      end else begin
         want = nearest_results.pop_front();
         if (got.tag != want.tag || got.index != want.index || got.dist_sq != want.dist_sq ||
             got.found != want.found) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result mismatch: expected tag %0d index %0d dist %0d found %0d, %s",
                        want.tag, want.index, want.dist_sq, want.found,
                        $sformatf("got tag %0d index %0d dist %0d found %0d",
                                  got.tag, got.index, got.dist_sq, got.found));
         end
      end
   endfunction

   always @(posedge clock) begin
      req_accepted = req_tvalid && req_tready;
      if (!reset) begin
         if (csr_valid && csr_ready) match_threshold = csr_data;
         if (req_accepted) track_item(bus_item);
         if (rsp_tvalid && rsp_tready)
            check_result({rsp_tdata[TAG_W-1:0],
                          rsp_tdata[TAG_W+INDEX_OUT_W-1:TAG_W],
                          rsp_tdata[TAG_W+INDEX_OUT_W+DIST_OUT_W-1:TAG_W+INDEX_OUT_W],
                          rsp_tuser[0]});
      end
   end

   // The sender offers beats in bursts separated by random gaps.
   always @(negedge clock) begin
      if (!req_tvalid || req_accepted) begin
         if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (request_beats.size() != 0) begin
            bus_item = request_beats.pop_front();
            req_tdata  <= REQ_TDATA_W'({bus_item.tag, bus_item.z, bus_item.y, bus_item.x});
            req_tuser  <= bus_item.op;
            req_tvalid <= 1'b1;
            if (burst_left != 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 15);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 :
                          (($urandom_range(0, 7) == 0) ? $urandom_range(15, 30)
                                                       : $urandom_range(1, 6));
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_request != 0 && hold_left == 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 1);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ((ready_cycle % 5) < 3);
         endcase
      end
      ready_cycle++;
      if (ready_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
   end

   function automatic void queue_item(logic [OP_W-1:0] op, logic signed [COORD_BITS-1:0] x,
                                      logic signed [COORD_BITS-1:0] y,
                                      logic signed [COORD_BITS-1:0] z);
      request_type it;
      it = '0;
      it.op  = op;
      it.x   = x;
      it.y   = y;
      it.z   = z;
      it.tag = TAG_W'($urandom);
      request_beats = {request_beats, it};
   endfunction

   function automatic logic signed [COORD_BITS-1:0] pick_coord(
         logic signed [COORD_BITS-1:0] center);
      case ($urandom_range(0, 7))
         0: return COORD_BITS'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         2, 3: return center + COORD_BITS'($urandom_range(0, 512)) - 16'sd256;
         default: return center + COORD_BITS'($urandom_range(0, 8)) - 16'sd4;
      endcase
   endfunction

   function automatic logic [THR_W-1:0] pick_threshold(int phase);
      case (phase)
         0: return THR_MAX;
         1: return THR_W'(1);
         2, 4: return '0;
         default: begin
            case ($urandom_range(0, 5))
               0: return '0;
               1: return THR_MAX;
               2: return THR_W'($urandom_range(1, 64));
               3: return THR_W'($urandom_range(1, 5000));
               4: return THR_W'($urandom_range(1, 200000));
               default: return THR_W'({$urandom, $urandom});
            endcase
         end
      endcase
   endfunction

   function automatic void queue_random_phase();
      logic signed [COORD_BITS-1:0] cx, cy, cz, px, py, pz;
      int n_points, n_queries;
      cx = COORD_BITS'($urandom);
      cy = COORD_BITS'($urandom);
      cz = COORD_BITS'($urandom);
      px = cx;
      py = cy;
      pz = cz;
      if ($urandom_range(0, 3) != 0) begin
         queue_item(OP_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom),
                    COORD_BITS'($urandom));
         random_items++;
      end
      n_points = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 24);
      for (int k = 0; k < n_points; k++) begin
         px = pick_coord(cx);
         py = pick_coord(cy);
         pz = pick_coord(cz);
         queue_item(OP_APPEND, px, py, pz);
      end
      random_items += n_points;
      n_queries = $urandom_range(4, 16);
      for (int k = 0; k < n_queries; k++) begin
         case ($urandom_range(0, 11))
            0: queue_item(OP_UNUSED, COORD_BITS'($urandom), COORD_BITS'($urandom),
                          COORD_BITS'($urandom));
            1: begin
               px = pick_coord(cx);
               py = pick_coord(cy);
               pz = pick_coord(cz);
               queue_item(OP_APPEND, px, py, pz);
               random_items++;
            end
            2, 3, 4: begin
               queue_item(OP_QUERY, px, py, pz);
               random_items++;
            end
            default: begin
               queue_item(OP_QUERY, pick_coord(cx), pick_coord(cy), pick_coord(cz));
               random_items++;
            end
         endcase
      end
   endfunction

   task automatic drain_all();
      while (request_beats.size() != 0 || req_tvalid || nearest_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] value);
      drain_all();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int row = 0; row < DIRECTED_ROWS; row++)
         request_beats = {request_beats, directed_table[row]};
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         write_threshold(pick_threshold(phase));
         if (phase == 3) hold_request = HOLD_CYCLES;
         queue_random_phase();
         phase++;
      end
      drain_all();
      if (mismatch_count == 0 && nearest_results.size() == 0)
         $display("tb_nearest_point_search_core: done, clean");
      else
         $display("tb_nearest_point_search_core: done, errors");
      $finish;
   end

endmodule

[filelist.f]
hdl/nps_pkg.sv
hdl/nps_dist.sv
hdl/nearest_point_search_core.sv
tb/sv/tb_nearest_point_search_core.sv
